// File: hw/rtl/c8x_pkg.sv
`timescale 1ns / 1ps
package c8x_pkg;

  localparam int unsigned ADDR_BITS   = 12;
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned SP_BITS     = $clog2(STACK_DEPTH);
  localparam int unsigned DEPTH_BITS  = SP_BITS + 1;

  localparam logic [ADDR_BITS-1:0]  PC_RESET    = ADDR_BITS'(12'h200);
  localparam logic [7:0]            SOUND_RESET = 8'd10;
  localparam logic [DEPTH_BITS-1:0] STACK_FULL  = DEPTH_BITS'(STACK_DEPTH);

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [7:0] EX_SKP  = 8'h9E;
  localparam logic [7:0] EX_SKNP = 8'hA1;
  localparam logic [7:0] FX_GDT  = 8'h07;
  localparam logic [7:0] FX_KEY  = 8'h0A;
  localparam logic [7:0] FX_SDT  = 8'h15;
  localparam logic [7:0] FX_SST  = 8'h18;
  localparam logic [7:0] FX_ADDI = 8'h1E;
  localparam logic [7:0] FX_FONT = 8'h29;

  localparam logic [3:0] REG_VF = 4'hF;
  localparam logic [3:0] REG_V0 = 4'h0;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_CLEAR   = 3'd1,
    ST_DRAW    = 3'd2,
    ST_WAITKEY = 3'd3,
    ST_IGNORED = 3'd4,
    ST_STACK   = 3'd5
  } status_t;

  typedef struct packed {
    logic [15:0] instruction;
    logic [15:0] keys;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] next_pc;
    status_t              status;
    logic [ADDR_BITS-1:0] index_value;
    logic [7:0]           vx_value;
    logic [7:0]           vy_value;
    logic [3:0]           sprite_rows;
    logic                 sound_on;
  } out_item_t;

endpackage

// File: hw/rtl/chip8_instruction_execute.sv
`timescale 1ns / 1ps
// CHIP-8 execute unit: one instruction beat in, one result beat out, one beat per cycle
// sustained while out_stall does not back up the result queue. An instruction is accepted,
// its V registers and the stack top are read from synchronous RAM in that cycle, and it
// executes and writes back in the next, with write forwarding on the RAM reads. A
// three-deep result queue absorbs output stalls. font_base is written through
// cfg_valid/cfg_ready (always ready).
module chip8_instruction_execute (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  c8x_pkg::in_item_t            in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output c8x_pkg::out_item_t           out_item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [c8x_pkg::ADDR_BITS-1:0] cfg_data
);

  localparam int unsigned AB = c8x_pkg::ADDR_BITS;
  localparam int unsigned DB = c8x_pkg::DEPTH_BITS;

  // architectural state in flops
  logic [AB-1:0] pc, pc_next, index_reg, index_next, font_base;
  logic [c8x_pkg::DEPTH_BITS-1:0] depth, depth_next;
  logic [7:0] delay_count, delay_next, sound_count, sound_next;
  logic key_wait, key_wait_next;
  logic [3:0] kw_reg, kw_reg_next;
  logic [7:0] vf, vf_next, v0, v0_next;

  // memories
  logic [7:0]    vmem [16];
  logic [15:0]   vok;
  logic [AB-1:0] smem [c8x_pkg::STACK_DEPTH];

  // execute stage
  logic          s1_valid;
  c8x_pkg::in_item_t s1_item;
  logic [7:0]    rdx, rdy;
  logic [AB-1:0] rds;

  // result queue
  c8x_pkg::out_item_t q [3];
  logic [1:0] wr_ptr, rd_ptr, cnt;
  logic [2:0] fill;
  logic accept, pop;
  c8x_pkg::out_item_t res;

  // write-back controls
  logic       pw;
  logic [3:0] pa;
  logic [7:0] pd;
  logic       fw;
  logic [7:0] fd;
  logic       sw;
  logic [c8x_pkg::SP_BITS-1:0] swa, sra;
  logic [AB-1:0] swd;
  logic [3:0] ax, ay;

  assign cfg_ready = 1'b1;
  assign fill      = {1'b0, cnt} + {2'b00, s1_valid};
  assign in_stall  = (fill >= 3'd3);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_item  = q[rd_ptr];

  // read addresses follow the state as it leaves the execute stage
  assign ax  = key_wait_next ? kw_reg_next : in_item.instruction[11:8];
  assign ay  = in_item.instruction[7:4];
  assign sra = c8x_pkg::SP_BITS'(depth_next - DB'(1));

  // a V register reads as zero until it is first written
  always_ff @(posedge clk) begin
    if (pw && pa != c8x_pkg::REG_VF) vmem[pa] <= pd;
    rdx <= (pw && pa == ax) ? pd : (vok[ax] ? vmem[ax] : 8'd0);
    rdy <= (pw && pa == ay) ? pd : (vok[ay] ? vmem[ay] : 8'd0);
    if (sw) smem[swa] <= swd;
    rds <= (sw && swa == sra) ? swd : smem[sra];
    s1_item <= in_item;
    if (s1_valid) q[wr_ptr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= c8x_pkg::PC_RESET;
      index_reg <= '0;
      font_base <= '0;
      depth <= '0;
      delay_count <= '0;
      sound_count <= c8x_pkg::SOUND_RESET;
      key_wait <= 1'b0;
      kw_reg <= '0;
      vf <= '0;
      v0 <= '0;
      vok <= '0;
      s1_valid <= 1'b0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      pc <= pc_next;
      index_reg <= index_next;
      depth <= depth_next;
      delay_count <= delay_next;
      sound_count <= sound_next;
      key_wait <= key_wait_next;
      kw_reg <= kw_reg_next;
      vf <= vf_next;
      v0 <= v0_next;
      if (pw) vok[pa] <= 1'b1;
      if (cfg_valid) font_base <= cfg_data;
      s1_valid <= accept;
      if (s1_valid) wr_ptr <= (wr_ptr == 2'd2) ? 2'd0 : wr_ptr + 2'd1;
      if (pop) rd_ptr <= (rd_ptr == 2'd2) ? 2'd0 : rd_ptr + 2'd1;
      cnt <= cnt + {1'b0, s1_valid} - {1'b0, pop};
    end
  end

  always_comb begin
    logic [15:0] op;
    logic [3:0] x, y, n, hk;
    logic [7:0] nn, a, b, vxo, vyo;
    logic [AB-1:0] nnn, step;
    logic [8:0] sum;
    logic jumped;
    c8x_pkg::status_t st;
    logic [3:0] rows;

    op  = s1_item.instruction;
    x   = op[11:8];
    y   = op[7:4];
    n   = op[3:0];
    nn  = op[7:0];
    nnn = op[11:0];
    a   = (key_wait ? kw_reg : x) == c8x_pkg::REG_VF ? vf : rdx;
    b   = (y == c8x_pkg::REG_VF) ? vf : rdy;
    hk  = '0;
    sum = '0;
    step = AB'(2);
    jumped = 1'b0;
    st = c8x_pkg::ST_OK;
    rows = '0;
    pw = 1'b0; pa = x; pd = '0;
    fw = 1'b0; fd = '0;
    sw = 1'b0; swa = c8x_pkg::SP_BITS'(depth); swd = pc + AB'(2);

    pc_next = pc;
    index_next = index_reg;
    depth_next = depth;
    delay_next = delay_count;
    sound_next = sound_count;
    key_wait_next = key_wait;
    kw_reg_next = kw_reg;

    if (s1_valid) begin
      if (sound_count != 8'd0) sound_next = sound_count - 8'd1;
      if (delay_count != 8'd0) delay_next = delay_count - 8'd1;
      if (key_wait) begin
        st = c8x_pkg::ST_WAITKEY;
        for (int k = 0; k < 16; k++) begin
          if (s1_item.keys[k]) hk = 4'(k);
        end
        pa = kw_reg;
        if (s1_item.keys != 16'd0) begin
          pw = 1'b1;
          pd = {4'd0, hk};
          key_wait_next = 1'b0;
          st = c8x_pkg::ST_OK;
        end
        jumped = 1'b1;
      end else begin
        unique case (op[15:12])
          4'h0: begin
            if (op == c8x_pkg::OP_CLS) st = c8x_pkg::ST_CLEAR;
            else if (op == c8x_pkg::OP_RET) begin
              if (depth == '0) st = c8x_pkg::ST_STACK;
              else begin
                depth_next = depth - DB'(1);
                pc_next = rds;
                jumped = 1'b1;
              end
            end else st = c8x_pkg::ST_IGNORED;
          end
          4'h1: begin pc_next = nnn; jumped = 1'b1; end
          4'h2: begin
            if (depth >= c8x_pkg::STACK_FULL) st = c8x_pkg::ST_STACK;
            else begin
              sw = 1'b1;
              depth_next = depth + DB'(1);
              pc_next = nnn;
              jumped = 1'b1;
            end
          end
          4'h3: if (a == nn) step = AB'(4);
          4'h4: if (a != nn) step = AB'(4);
          4'h5: begin
            if (n != 4'd0) st = c8x_pkg::ST_IGNORED;
            else if (a == b) step = AB'(4);
          end
          4'h6: begin pw = 1'b1; pd = nn; end
          4'h7: begin pw = 1'b1; pd = a + nn; end
          4'h8: begin
            case (n)
              4'h0: begin pw = 1'b1; pd = b; end
              4'h1: begin pw = 1'b1; pd = a | b; end
              4'h2: begin pw = 1'b1; pd = a & b; end
              4'h3: begin pw = 1'b1; pd = a ^ b; end
              4'h4: begin
                sum = {1'b0, a} + {1'b0, b};
                pw = 1'b1; pd = sum[7:0];
                fw = 1'b1; fd = {7'd0, sum[8]};
              end
              4'h5: begin
                pw = 1'b1; pd = a - b;
                fw = 1'b1; fd = {7'd0, a > b};
              end
              4'h6: begin
                pw = 1'b1; pd = {1'b0, a[7:1]};
                fw = 1'b1; fd = {7'd0, a[0]};
              end
              4'h7: begin
                pw = 1'b1; pd = b - a;
                fw = 1'b1; fd = {7'd0, b > a};
              end
              4'hE: begin
                pw = 1'b1; pd = {a[6:0], 1'b0};
                fw = 1'b1; fd = {7'd0, a[7]};
              end
              default: st = c8x_pkg::ST_IGNORED;
            endcase
          end
          4'h9: begin
            if (n != 4'd0) st = c8x_pkg::ST_IGNORED;
            else if (a != b) step = AB'(4);
          end
          4'hA: index_next = nnn;
          4'hB: begin pc_next = AB'(v0) + nnn; jumped = 1'b1; end
          4'hC: st = c8x_pkg::ST_IGNORED;
          4'hD: begin st = c8x_pkg::ST_DRAW; rows = n; end
          4'hE: begin
            if (nn == c8x_pkg::EX_SKP) begin
              if (s1_item.keys[a[3:0]]) step = AB'(4);
            end else if (nn == c8x_pkg::EX_SKNP) begin
              if (!s1_item.keys[a[3:0]]) step = AB'(4);
            end else st = c8x_pkg::ST_IGNORED;
          end
          4'hF: begin
            case (nn)
              c8x_pkg::FX_GDT:  begin pw = 1'b1; pd = delay_next; end
              c8x_pkg::FX_KEY:  begin
                key_wait_next = 1'b1;
                kw_reg_next = x;
                st = c8x_pkg::ST_WAITKEY;
              end
              c8x_pkg::FX_SDT:  delay_next = a;
              c8x_pkg::FX_SST:  sound_next = a;
              c8x_pkg::FX_ADDI: index_next = index_reg + AB'(a);
              c8x_pkg::FX_FONT: index_next = font_base + AB'({a[3:0], 2'b00})
                                             + AB'(a[3:0]);
              default: st = c8x_pkg::ST_IGNORED;
            endcase
          end
          default: st = c8x_pkg::ST_IGNORED;
        endcase
      end
      if (!jumped) pc_next = pc + step;
    end

    // flag write lands after the result, so it wins on VF
    if (fw) vf_next = fd;
    else if (pw && pa == c8x_pkg::REG_VF) vf_next = pd;
    else vf_next = vf;
    v0_next = (pw && pa == c8x_pkg::REG_V0) ? pd : v0;

    if (key_wait) begin
      vxo = (pa == c8x_pkg::REG_VF) ? vf_next : (pw ? pd : a);
      vyo = '0;
    end else begin
      vxo = (x == c8x_pkg::REG_VF) ? vf_next : ((pw && pa == x) ? pd : a);
      vyo = (y == c8x_pkg::REG_VF) ? vf_next : ((pw && pa == y) ? pd : b);
    end

    res.next_pc     = pc_next;
    res.status      = st;
    res.index_value = index_next;
    res.vx_value    = vxo;
    res.vy_value    = vyo;
    res.sprite_rows = rows;
    res.sound_on    = (sound_next != 8'd0);
  end

endmodule

// File: hw/rtl/c8x_checker.sv
`timescale 1ns / 1ps
module c8x_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input c8x_pkg::out_item_t out_item
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result beat changed under stall");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat shown right after reset");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.status <= c8x_pkg::ST_STACK)
    else $error("status code out of range");

  a_rows_draw: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != c8x_pkg::ST_DRAW |-> out_item.sprite_rows == 4'd0)
    else $error("sprite rows on a non-draw result");

  // no result appears from an empty queue without an accepted beat that passed the execute stage
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(in_valid && !in_stall, 2))
    else $error("result beat without an instruction");

endmodule

bind chip8_instruction_execute c8x_checker u_c8x_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;

  typedef enum logic [3:0] {
    G_SYS, G_JP, G_CALL, G_SEQ, G_SNE, G_SRE, G_LD, G_ADD,
    G_ALU, G_SRNE, G_LDI, G_JPV, G_RND, G_DRW, G_KEY, G_MISC
  } group_t;

  typedef enum logic [3:0] {
    A_MOV = 4'h0, A_OR = 4'h1, A_AND = 4'h2, A_XOR = 4'h3, A_ADD = 4'h4,
    A_SUB = 4'h5, A_SHR = 4'h6, A_SUBN = 4'h7, A_SHL = 4'hE
  } alu_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  c8x_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  c8x_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [c8x_pkg::ADDR_BITS-1:0] cfg_data = '0;

  chip8_instruction_execute i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  c8x_pkg::in_item_t pending_instrs[$];
  c8x_pkg::out_item_t expected_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int errors = 0;

  // machine copy
  logic [7:0] vregs[16];
  logic [c8x_pkg::ADDR_BITS-1:0] index_reg, pc_reg, font_base;
  logic [c8x_pkg::ADDR_BITS-1:0] ret_stack[c8x_pkg::STACK_DEPTH];
  logic [c8x_pkg::DEPTH_BITS-1:0] depth;
  logic [7:0] delay_count, sound_count;
  logic key_waiting;
  logic [3:0] key_reg;

  initial forever #1 clk = ~clk;

  function automatic void execute_instr(c8x_pkg::in_item_t it);
    logic [15:0] op;
    logic [3:0] x, y, n, rows;
    logic [7:0] nn, a, b;
    logic [c8x_pkg::ADDR_BITS-1:0] nnn;
    logic [8:0] sum;
    logic [3:0] step;
    logic jumped;
    c8x_pkg::status_t st;
    c8x_pkg::out_item_t r;
    op = it.instruction;
    x = op[11:8];
    y = op[7:4];
    n = op[3:0];
    nn = op[7:0];
    nnn = op[11:0];
    rows = '0;
    step = 4'd2;
    jumped = 1'b0;
    st = c8x_pkg::ST_OK;
    if (sound_count != 0) sound_count--;
    if (delay_count != 0) delay_count--;
    if (key_waiting) begin
      st = c8x_pkg::ST_WAITKEY;
      for (int k = 0; k < 16; k++) begin
        if (it.keys[k]) begin
          vregs[key_reg] = 8'(k);
          key_waiting = 1'b0;
          st = c8x_pkg::ST_OK;
        end
      end
      r.next_pc = pc_reg;
      r.status = st;
      r.index_value = index_reg;
      r.vx_value = vregs[key_reg];
      r.vy_value = '0;
      r.sprite_rows = '0;
      r.sound_on = sound_count != 0;
      expected_results.push_back(r);
      return;
    end
    a = vregs[x];
    b = vregs[y];
    case (group_t'(op[15:12]))
      G_SYS: begin
        if (op == c8x_pkg::OP_CLS) st = c8x_pkg::ST_CLEAR;
        else if (op == c8x_pkg::OP_RET) begin
          if (depth == 0) st = c8x_pkg::ST_STACK;
          else begin
            depth--;
            pc_reg = ret_stack[depth];
            jumped = 1'b1;
          end
        end else st = c8x_pkg::ST_IGNORED;
      end
      G_JP: begin
        pc_reg = nnn;
        jumped = 1'b1;
      end
      G_CALL: begin
        if (depth >= c8x_pkg::STACK_FULL) st = c8x_pkg::ST_STACK;
        else begin
          ret_stack[depth] = pc_reg + 12'd2;
          depth++;
          pc_reg = nnn;
          jumped = 1'b1;
        end
      end
      G_SEQ: if (a == nn) step = 4'd4;
      G_SNE: if (a != nn) step = 4'd4;
      G_SRE: if (n != 0) st = c8x_pkg::ST_IGNORED; else if (a == b) step = 4'd4;
      G_LD: vregs[x] = nn;
      G_ADD: vregs[x] = a + nn;
      G_ALU: begin
        case (n)
          A_MOV: vregs[x] = b;
          A_OR: vregs[x] = a | b;
          A_AND: vregs[x] = a & b;
          A_XOR: vregs[x] = a ^ b;
          A_ADD: begin
            sum = {1'b0, a} + {1'b0, b};
            vregs[x] = sum[7:0];
            vregs[c8x_pkg::REG_VF] = {7'd0, sum[8]};
          end
          A_SUB: begin
            vregs[x] = a - b;
            vregs[c8x_pkg::REG_VF] = {7'd0, a > b};
          end
          A_SHR: begin
            vregs[x] = a >> 1;
            vregs[c8x_pkg::REG_VF] = {7'd0, a[0]};
          end
          A_SUBN: begin
            vregs[x] = b - a;
            vregs[c8x_pkg::REG_VF] = {7'd0, b > a};
          end
          A_SHL: begin
            vregs[x] = a << 1;
            vregs[c8x_pkg::REG_VF] = {7'd0, a[7]};
          end
          default: st = c8x_pkg::ST_IGNORED;
        endcase
      end
      G_SRNE: if (n != 0) st = c8x_pkg::ST_IGNORED; else if (a != b) step = 4'd4;
      G_LDI: index_reg = nnn;
      G_JPV: begin
        pc_reg = vregs[c8x_pkg::REG_V0] + nnn;
        jumped = 1'b1;
      end
      G_RND: st = c8x_pkg::ST_IGNORED;
      G_DRW: begin
        st = c8x_pkg::ST_DRAW;
        rows = n;
      end
      G_KEY: begin
        if (nn == c8x_pkg::EX_SKP) begin
          if (it.keys[a[3:0]]) step = 4'd4;
        end else if (nn == c8x_pkg::EX_SKNP) begin
          if (!it.keys[a[3:0]]) step = 4'd4;
        end else st = c8x_pkg::ST_IGNORED;
      end
      default: begin
        case (nn)
          c8x_pkg::FX_GDT: vregs[x] = delay_count;
          c8x_pkg::FX_KEY: begin
            key_waiting = 1'b1;
            key_reg = x;
            st = c8x_pkg::ST_WAITKEY;
          end
          c8x_pkg::FX_SDT: delay_count = a;
          c8x_pkg::FX_SST: sound_count = a;
          c8x_pkg::FX_ADDI: index_reg = index_reg + a;
          c8x_pkg::FX_FONT: index_reg = font_base + 12'(5 * a[3:0]);
          default: st = c8x_pkg::ST_IGNORED;
        endcase
      end
    endcase
    if (!jumped) pc_reg = pc_reg + step;
    r.next_pc = pc_reg;
    r.status = st;
    r.index_value = index_reg;
    r.vx_value = vregs[x];
    r.vy_value = vregs[y];
    r.sprite_rows = rows;
    r.sound_on = sound_count != 0;
    expected_results.push_back(r);
  endfunction

  task automatic report_mismatch(string what, logic [15:0] exp_v, logic [15:0] got_v);
    $display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  // sender: advance on acceptance, hold while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) execute_instr(in_item);
      if (pending_instrs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_item <= pending_instrs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    c8x_pkg::out_item_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", '0, out_item.next_pc);
        end else begin
          e = expected_results.pop_front();
          if (out_item.next_pc !== e.next_pc)
            report_mismatch("next_pc", e.next_pc, out_item.next_pc);
          if (out_item.status !== e.status)
            report_mismatch("status", e.status, out_item.status);
          if (out_item.index_value !== e.index_value)
            report_mismatch("index_value", e.index_value, out_item.index_value);
          if (out_item.vx_value !== e.vx_value)
            report_mismatch("vx_value", e.vx_value, out_item.vx_value);
          if (out_item.vy_value !== e.vy_value)
            report_mismatch("vy_value", e.vy_value, out_item.vy_value);
          if (out_item.sprite_rows !== e.sprite_rows)
            report_mismatch("sprite_rows", e.sprite_rows, out_item.sprite_rows);
          if (out_item.sound_on !== e.sound_on)
            report_mismatch("sound_on", e.sound_on, out_item.sound_on);
        end
      end
      out_stall <= $urandom_range(0, 99) < recv_stall_pct;
    end
  end

  task automatic push_instr(logic [15:0] op, logic [15:0] keys);
    c8x_pkg::in_item_t it;
    it.instruction = op;
    it.keys = keys;
    pending_instrs.push_back(it);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'hFF;
      3: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_keys();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'h0001 << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_instr();
    logic [3:0] x, y, n;
    logic [7:0] fx[6];
    x = 4'($urandom);
    y = 4'($urandom);
    n = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h0;
    fx = '{c8x_pkg::FX_GDT, c8x_pkg::FX_KEY, c8x_pkg::FX_SDT, c8x_pkg::FX_SST,
           c8x_pkg::FX_ADDI, c8x_pkg::FX_FONT};
    case ($urandom_range(0, 19))
      0: return c8x_pkg::OP_CLS;
      1: return c8x_pkg::OP_RET;
      2: return {G_SYS, 12'($urandom)};
      3: return {G_JP, 12'($urandom)};
      4: return {G_CALL, 12'($urandom)};
      5: return {G_SEQ, x, pick_byte()};
      6: return {G_SNE, x, pick_byte()};
      7: return {G_SRE, x, y, n};
      8, 9: return {G_LD, x, pick_byte()};
      10: return {G_ADD, x, pick_byte()};
      11, 12: return {G_ALU, x, y, 4'($urandom)};
      13: return {G_SRNE, x, y, n};
      14: return {($urandom_range(0, 1) ? G_LDI : G_JPV), 12'($urandom)};
      15: return {($urandom_range(0, 1) ? G_RND : G_DRW), 12'($urandom)};
      16: return {G_KEY, x, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                            : ($urandom_range(0, 1) ? c8x_pkg::EX_SKP : c8x_pkg::EX_SKNP)};
      default: return {G_MISC, x, ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                  : fx[$urandom_range(0, 5)]};
    endcase
  endfunction

  // sample between edges so the sender's updates have settled
  task automatic wait_idle();
    while (pending_instrs.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_font(logic [c8x_pkg::ADDR_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    font_base = v;
  endtask

  initial begin
    logic [c8x_pkg::ADDR_BITS-1:0] fonts[4];
    int unsigned idle_mix[4][2];
    int cnt;
    for (int i = 0; i < 16; i++) vregs[i] = '0;
    index_reg = '0;
    pc_reg = c8x_pkg::PC_RESET;
    depth = '0;
    delay_count = '0;
    sound_count = c8x_pkg::SOUND_RESET;
    key_waiting = 1'b0;
    key_reg = '0;
    font_base = '0;
    fonts = '{12'hFFF, 12'h000, 12'($urandom), 12'hFFB};
    idle_mix = '{'{0, 0}, '{73, 0}, '{0, 73}, '{38, 38}};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < 4; p++) begin
      write_font(fonts[p]);
      send_idle_pct = idle_mix[p][0];
      recv_stall_pct = idle_mix[p][1];
      if (p == 0) begin
        push_instr(c8x_pkg::OP_CLS, 16'h0000);
        push_instr(c8x_pkg::OP_RET, 16'hFFFF);
        push_instr({G_LD, 4'h0, 8'hFF}, 16'h0000);
        push_instr({G_LD, 4'h1, 8'h01}, 16'h0000);
        push_instr({G_ALU, 4'h0, 4'h1, A_ADD}, 16'h0000);
        push_instr({G_LD, 4'hF, 8'h81}, 16'h0000);
        push_instr({G_ALU, 4'hF, 4'h0, A_SHR}, 16'h0000);
        push_instr({G_ALU, 4'h1, 4'h2, A_SUB}, 16'h0000);
        push_instr({G_ALU, 4'h1, 4'h2, A_SUBN}, 16'h0000);
        push_instr({G_ALU, 4'h1, 4'h2, A_SHL}, 16'h0000);
        push_instr({G_ALU, 4'h1, 4'h2, 4'h8}, 16'h0000);
        push_instr({G_SRE, 4'h1, 4'h2, 4'h1}, 16'h0000);
        push_instr({G_SRNE, 4'h1, 4'h2, 4'h0}, 16'h0000);
        push_instr({G_SEQ, 4'h0, 8'h00}, 16'h0000);
        push_instr({G_LDI, 12'hFFF}, 16'h0000);
        push_instr({G_MISC, 4'h1, c8x_pkg::FX_ADDI}, 16'h0000);
        push_instr({G_MISC, 4'h1, c8x_pkg::FX_FONT}, 16'h0000);
        push_instr({G_CALL, 12'hABC}, 16'h0000);
        push_instr(c8x_pkg::OP_RET, 16'h0000);
        push_instr({G_JPV, 12'hFFF}, 16'h0000);
        push_instr({G_DRW, 12'h12F}, 16'h0000);
        push_instr({G_KEY, 4'h1, c8x_pkg::EX_SKP}, 16'hFFFF);
        push_instr({G_KEY, 4'h1, c8x_pkg::EX_SKNP}, 16'h0000);
        push_instr({G_MISC, 4'h1, c8x_pkg::FX_SST}, 16'h0000);
        push_instr({G_MISC, 4'h2, c8x_pkg::FX_KEY}, 16'h0000);
        push_instr(16'hFFFF, 16'h0000);
        push_instr(16'h0000, 16'h8000);
      end
      cnt = 0;
      while (cnt < 150) begin
        if ($urandom_range(0, 99) < 3) begin
          // overflow the return stack, then unwind past empty
          for (int i = 0; i < c8x_pkg::STACK_DEPTH + 1; i++)
            push_instr({G_CALL, 12'($urandom)}, '0);
          for (int i = 0; i < c8x_pkg::STACK_DEPTH + 1; i++)
            push_instr(c8x_pkg::OP_RET, pick_keys());
          cnt += 2 * (c8x_pkg::STACK_DEPTH + 1);
        end else begin
          push_instr(pick_instr(), pick_keys());
          cnt++;
        end
      end
      wait_idle();
    end
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/c8x_pkg.sv
hw/rtl/chip8_instruction_execute.sv
hw/rtl/c8x_checker.sv
tb/tb.sv
